/* sv/nbstat_pkg.sv */
package nbstat_pkg;

    localparam int NAME_BYTES   = 15;
    localparam int RECORD_BYTES = NAME_BYTES + 3;
    localparam int LEN_W        = $clog2(NAME_BYTES + 1);
    localparam int IDX_W        = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int RIDX_W       = $clog2(RECORD_BYTES + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // header layout
    localparam logic [3:0] HDR_BYTES   = 4'd12;
    localparam logic [3:0] ANCOUNT_HI  = 4'd6;
    localparam logic [3:0] ANCOUNT_LO  = 4'd7;
    localparam logic [3:0] FIXED_BYTES = 4'd10;

    localparam logic [7:0] PTR_MARK    = 8'hC0;
    localparam logic [7:0] GROUP_FLAG  = 8'h80;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] TYPE_WKSTA  = 8'h00;
    localparam logic [7:0] TYPE_SERVER = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_HOST   = 2'd0;
    localparam logic [1:0] KIND_GROUP  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NO_ANSWER = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_NO_HOST   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] char_value;
        logic [2:0] status_code;
        logic       last_of_run;
    } out_word_t;

    typedef logic [NAME_BYTES-1:0][7:0] name_t;

    // one finished packet, as handed from parser to emitter
    typedef struct packed {
        name_t             host_chars;
        logic [LEN_W-1:0]  host_len;
        name_t             group_chars;
        logic [LEN_W-1:0]  group_len;
        logic [2:0]        status;
    } summary_t;

endpackage

/* sv/nbstat_front.sv */
module nbstat_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nbstat_pkg::in_word_t in_word,
    input  logic                 queue_full,
    output logic                 push,
    output nbstat_pkg::summary_t push_word
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_PTR     = 3'd3;
    localparam logic [2:0] PH_FIXED   = 3'd4;
    localparam logic [2:0] PH_COUNT   = 3'd5;
    localparam logic [2:0] PH_RECORDS = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam int LEN_W  = nbstat_pkg::LEN_W;
    localparam int IDX_W  = nbstat_pkg::IDX_W;
    localparam int RIDX_W = nbstat_pkg::RIDX_W;

    logic [2:0]        phase_reg, phase_next;
    logic [3:0]        header_count_reg, header_count_next;
    logic [7:0]        answer_high_reg, answer_high_next;
    logic              answers_present_reg, answers_present_next;
    logic [7:0]        skip_left_reg, skip_left_next;
    logic [3:0]        fixed_left_reg, fixed_left_next;
    logic [7:0]        names_left_reg, names_left_next;
    logic [RIDX_W-1:0] record_index_reg, record_index_next;
    logic [LEN_W-1:0]  record_len_reg, record_len_next;
    logic              record_stopped_reg, record_stopped_next;
    logic [7:0]        record_type_reg, record_type_next;
    logic              record_group_reg, record_group_next;
    logic [LEN_W-1:0]  host_len_reg, host_len_next;
    logic [LEN_W-1:0]  group_len_reg, group_len_next;

    nbstat_pkg::name_t record_chars_reg, record_chars_next;
    nbstat_pkg::name_t host_chars_reg, host_chars_next;
    nbstat_pkg::name_t group_chars_reg, group_chars_next;

    logic       in_fire;
    logic       commit;
    logic [7:0] b;
    logic [2:0] status;
    logic       names_out;

    assign in_stall = queue_full;
    assign in_fire  = in_valid && !in_stall;
    assign b        = in_word.data_byte;

    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        answer_high_next     = answer_high_reg;
        answers_present_next = answers_present_reg;
        skip_left_next       = skip_left_reg;
        fixed_left_next      = fixed_left_reg;
        names_left_next      = names_left_reg;
        record_index_next    = record_index_reg;
        record_len_next      = record_len_reg;
        record_stopped_next  = record_stopped_reg;
        record_type_next     = record_type_reg;
        record_group_next    = record_group_reg;
        host_len_next        = host_len_reg;
        group_len_next       = group_len_reg;
        record_chars_next    = record_chars_reg;
        host_chars_next      = host_chars_reg;
        group_chars_next     = group_chars_reg;
        commit               = 1'b0;
        status               = nbstat_pkg::ST_OK;
        names_out            = 1'b0;
        push                 = 1'b0;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg == nbstat_pkg::ANCOUNT_HI)
                        answer_high_next = b;
                    if (header_count_reg == nbstat_pkg::ANCOUNT_LO)
                        answers_present_next = (answer_high_reg | b) != 8'd0;
                    header_count_next = header_count_reg + 4'd1;
                    if (header_count_next >= nbstat_pkg::HDR_BYTES)
                        phase_next = answers_present_next ? PH_NAME : PH_DONE;
                end
                PH_NAME:
                begin
                    if (b == 8'd0)
                    begin
                        fixed_left_next = nbstat_pkg::FIXED_BYTES;
                        phase_next      = PH_FIXED;
                    end
                    else if ((b & nbstat_pkg::PTR_MARK) == nbstat_pkg::PTR_MARK)
                    begin
                        phase_next = PH_PTR;
                    end
                    else
                    begin
                        skip_left_next = b;
                        phase_next     = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (skip_left_reg != 8'd0)
                        skip_left_next = skip_left_reg - 8'd1;
                    if (skip_left_next == 8'd0)
                        phase_next = PH_NAME;
                end
                PH_PTR:
                begin
                    fixed_left_next = nbstat_pkg::FIXED_BYTES;
                    phase_next      = PH_FIXED;
                end
                PH_FIXED:
                begin
                    if (fixed_left_reg != 4'd0)
                        fixed_left_next = fixed_left_reg - 4'd1;
                    if (fixed_left_next == 4'd0)
                        phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    names_left_next     = b;
                    record_index_next   = '0;
                    record_len_next     = '0;
                    record_stopped_next = 1'b0;
                    record_type_next    = 8'd0;
                    record_group_next   = 1'b0;
                    phase_next          = (b == 8'd0) ? PH_DONE : PH_RECORDS;
                end
                PH_RECORDS:
                begin
                    if (record_index_reg < RIDX_W'(nbstat_pkg::NAME_BYTES))
                    begin
                        if (!record_stopped_reg)
                        begin
                            if (b == nbstat_pkg::CHAR_SPACE || b == nbstat_pkg::CHAR_NUL)
                                record_stopped_next = 1'b1;
                            else if (record_len_reg < LEN_W'(nbstat_pkg::NAME_BYTES))
                            begin
                                record_chars_next[record_len_reg[IDX_W-1:0]] = b;
                                record_len_next = record_len_reg + 1'b1;
                            end
                        end
                    end
                    else if (record_index_reg == RIDX_W'(nbstat_pkg::NAME_BYTES))
                        record_type_next = b;
                    else if (record_index_reg == RIDX_W'(nbstat_pkg::NAME_BYTES + 1))
                        record_group_next = (b & nbstat_pkg::GROUP_FLAG) != 8'd0;
                    record_index_next = record_index_reg + 1'b1;
                    commit = record_index_next >= RIDX_W'(nbstat_pkg::RECORD_BYTES);
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // record complete: name, type and flags are all in the registers
        if (commit)
        begin
            if (record_len_reg != '0)
            begin
                if (!record_group_reg && host_len_reg == '0 &&
                    (record_type_reg == nbstat_pkg::TYPE_WKSTA ||
                     record_type_reg == nbstat_pkg::TYPE_SERVER))
                begin
                    host_chars_next = record_chars_reg;
                    host_len_next   = record_len_reg;
                end
                if (record_group_reg && group_len_reg == '0)
                begin
                    group_chars_next = record_chars_reg;
                    group_len_next   = record_len_reg;
                end
            end
            record_index_next   = '0;
            record_len_next     = '0;
            record_stopped_next = 1'b0;
            record_type_next    = 8'd0;
            record_group_next   = 1'b0;
            if (names_left_reg != 8'd0)
                names_left_next = names_left_reg - 8'd1;
            if (names_left_next == 8'd0)
                phase_next = PH_DONE;
        end

        if (phase_next == PH_HEADER)
            status = nbstat_pkg::ST_SHORT;
        else if (!answers_present_next)
            status = nbstat_pkg::ST_NO_ANSWER;
        else if (phase_next != PH_RECORDS && phase_next != PH_DONE)
            status = nbstat_pkg::ST_TRUNC;
        else if (host_len_next == '0)
            status = nbstat_pkg::ST_NO_HOST;
        else
            status = nbstat_pkg::ST_OK;

        names_out = (status == nbstat_pkg::ST_OK) || (status == nbstat_pkg::ST_NO_HOST);

        push_word.host_chars  = host_chars_next;
        push_word.host_len    = names_out ? host_len_next : '0;
        push_word.group_chars = group_chars_next;
        push_word.group_len   = names_out ? group_len_next : '0;
        push_word.status      = status;

        // last word: hand the summary over and start the next packet clean
        if (in_fire && in_word.end_of_packet)
        begin
            push                 = 1'b1;
            phase_next           = PH_HEADER;
            header_count_next    = 4'd0;
            answer_high_next     = 8'd0;
            answers_present_next = 1'b0;
            skip_left_next       = 8'd0;
            fixed_left_next      = nbstat_pkg::FIXED_BYTES;
            names_left_next      = 8'd0;
            record_index_next    = '0;
            record_len_next      = '0;
            record_stopped_next  = 1'b0;
            record_type_next     = 8'd0;
            record_group_next    = 1'b0;
            host_len_next        = '0;
            group_len_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HEADER;
            header_count_reg    <= 4'd0;
            answer_high_reg     <= 8'd0;
            answers_present_reg <= 1'b0;
            skip_left_reg       <= 8'd0;
            fixed_left_reg      <= nbstat_pkg::FIXED_BYTES;
            names_left_reg      <= 8'd0;
            record_index_reg    <= '0;
            record_len_reg      <= '0;
            record_stopped_reg  <= 1'b0;
            record_type_reg     <= 8'd0;
            record_group_reg    <= 1'b0;
            host_len_reg        <= '0;
            group_len_reg       <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            answer_high_reg     <= answer_high_next;
            answers_present_reg <= answers_present_next;
            skip_left_reg       <= skip_left_next;
            fixed_left_reg      <= fixed_left_next;
            names_left_reg      <= names_left_next;
            record_index_reg    <= record_index_next;
            record_len_reg      <= record_len_next;
            record_stopped_reg  <= record_stopped_next;
            record_type_reg     <= record_type_next;
            record_group_reg    <= record_group_next;
            host_len_reg        <= host_len_next;
            group_len_reg       <= group_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        record_chars_reg <= record_chars_next;
        host_chars_reg   <= host_chars_next;
        group_chars_reg  <= group_chars_next;
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_word.end_of_packet) |=>
            (phase_reg == PH_HEADER && header_count_reg == 4'd0 && host_len_reg == '0))
        else $error("parser did not restart after last word");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (host_len_reg <= LEN_W'(nbstat_pkg::NAME_BYTES)) &&
        (group_len_reg <= LEN_W'(nbstat_pkg::NAME_BYTES)) &&
        (record_len_reg <= LEN_W'(nbstat_pkg::NAME_BYTES)))
        else $error("name length out of range");

    a_records_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RECORDS) |-> (names_left_reg != 8'd0 &&
            record_index_reg < RIDX_W'(nbstat_pkg::RECORD_BYTES)))
        else $error("record phase with no names left");

    a_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER && phase_reg != PH_DONE) |-> answers_present_reg)
        else $error("answer parsing without an answer count");

endmodule

/* sv/nbstat_queue.sv */
module nbstat_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nbstat_pkg::summary_t push_word,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output nbstat_pkg::summary_t head_word
);

    localparam int QPTR_W = nbstat_pkg::QPTR_W;
    localparam int QCNT_W = nbstat_pkg::QCNT_W;

    nbstat_pkg::summary_t slots_reg [nbstat_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = count_reg == QCNT_W'(nbstat_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_word  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(nbstat_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(nbstat_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_word;
    end

endmodule

/* sv/nbstat_emit.sv */
module nbstat_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  nbstat_pkg::summary_t  head_word,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nbstat_pkg::out_word_t out_word
);

    localparam int LEN_W = nbstat_pkg::LEN_W;
    localparam int IDX_W = nbstat_pkg::IDX_W;

    logic [1:0]            sel_reg, sel_next;
    logic [LEN_W-1:0]      idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    nbstat_pkg::out_word_t out_word_reg, out_word_next;

    logic                  load;
    logic [LEN_W-1:0]      gidx;

    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        pop            = 1'b0;
        gidx           = (sel_reg == nbstat_pkg::KIND_HOST) ? '0 : idx_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (sel_reg == nbstat_pkg::KIND_HOST && idx_reg < head_word.host_len)
            begin
                out_word_next.item_kind   = nbstat_pkg::KIND_HOST;
                out_word_next.char_value  = head_word.host_chars[idx_reg[IDX_W-1:0]];
                out_word_next.status_code = nbstat_pkg::ST_OK;
                out_word_next.last_of_run = 1'b0;
                if (idx_reg + 1'b1 == head_word.host_len)
                begin
                    sel_next = nbstat_pkg::KIND_GROUP;
                    idx_next = '0;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            else if (sel_reg != nbstat_pkg::KIND_STATUS && gidx < head_word.group_len)
            begin
                out_word_next.item_kind   = nbstat_pkg::KIND_GROUP;
                out_word_next.char_value  = head_word.group_chars[gidx[IDX_W-1:0]];
                out_word_next.status_code = nbstat_pkg::ST_OK;
                out_word_next.last_of_run = 1'b0;
                idx_next = gidx + 1'b1;
                sel_next = (gidx + 1'b1 == head_word.group_len) ? nbstat_pkg::KIND_STATUS
                                                                : nbstat_pkg::KIND_GROUP;
            end
            else
            begin
                out_word_next.item_kind   = nbstat_pkg::KIND_STATUS;
                out_word_next.char_value  = 8'd0;
                out_word_next.status_code = head_word.status;
                out_word_next.last_of_run = 1'b1;
                pop      = 1'b1;
                sel_next = nbstat_pkg::KIND_HOST;
                idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= nbstat_pkg::KIND_HOST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

/* sv/netbios_node_status_parser_core.sv */
// NetBIOS node-status response parser.
// in_* channel: one packet byte per word, end_of_packet set on the final byte.
// out_* channel: for each packet, the host-name characters, then the workgroup
// characters (both only when the status is ok or no-host), then one status word
// with last_of_run set. Up to 31 words per packet.
// Input bytes are taken at one per cycle while in_stall is low; the parser
// updates its state in the same cycle. On the last byte the packet summary goes
// into a two-entry queue, and the emitter drains it at one word per cycle while
// out_stall is low. A packet's result words pass through the queue slot and then
// the output register. The next packet's bytes are accepted while earlier
// results drain; in_stall rises only when both queue slots hold packets still
// being emitted. A stall on the output holds out_word steady and backs up into
// the queue. Reset clears the parser to the start of a packet and empties the
// queue and the output register; no words are lost or repeated across stalls.
module netbios_node_status_parser_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  nbstat_pkg::in_word_t  in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nbstat_pkg::out_word_t out_word
);

    logic                 queue_full;
    logic                 push;
    nbstat_pkg::summary_t push_word;
    logic                 pop;
    logic                 head_valid;
    nbstat_pkg::summary_t head_word;

    nbstat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    nbstat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    nbstat_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

/* verif/netbios_node_status_parser_core_tb.sv */
module netbios_node_status_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nbstat_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;

    netbios_node_status_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Response parser prediction
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        PS_HEADER, PS_LABEL, PS_SKIP, PS_PTR, PS_FIXED, PS_COUNT, PS_RECORDS, PS_DONE
    } parse_state_e;

    parse_state_e ps = PS_HEADER;
    logic [3:0]   hdr_seen = '0;
    logic [7:0]   ancount_hi = '0;
    logic         have_answers = 1'b0;
    logic [7:0]   skip_cnt = '0;
    logic [3:0]   fixed_cnt = FIXED_BYTES;
    logic [7:0]   names_cnt = '0;
    logic [4:0]   rec_pos = '0;
    logic [7:0]   rec_name [NAME_BYTES];
    logic [3:0]   rec_len = '0;
    logic         rec_stop = 1'b0;
    logic [7:0]   rec_type = '0;
    logic         rec_grp = 1'b0;
    logic [7:0]   host_name [NAME_BYTES];
    logic [3:0]   host_len = '0;
    logic [7:0]   group_name [NAME_BYTES];
    logic [3:0]   group_len = '0;

    in_word_t  tx_bytes [$];
    out_word_t expected_words [$];
    logic [7:0] pkt [$];

    int mismatches = 0;
    int bytes_queued = 0;
    int packets_queued = 0;
    int bytes_taken = 0;
    int words_checked = 0;
    int status_seen [8];
    int hold_req = 0;

    task automatic start_record();
        rec_pos  = '0;
        rec_len  = '0;
        rec_stop = 1'b0;
        rec_type = '0;
        rec_grp  = 1'b0;
    endtask

    task automatic clear_parser();
        ps           = PS_HEADER;
        hdr_seen     = '0;
        ancount_hi   = '0;
        have_answers = 1'b0;
        skip_cnt     = '0;
        fixed_cnt    = FIXED_BYTES;
        names_cnt    = '0;
        host_len     = '0;
        group_len    = '0;
        start_record();
    endtask

    task automatic close_record();
        int i;
        if (rec_len != 0)
        begin
            if (!rec_grp && host_len == 0 &&
                (rec_type == TYPE_WKSTA || rec_type == TYPE_SERVER))
            begin
                for (i = 0; i < rec_len; i++)
                    host_name[i] = rec_name[i];
                host_len = rec_len;
            end
            if (rec_grp && group_len == 0)
            begin
                for (i = 0; i < rec_len; i++)
                    group_name[i] = rec_name[i];
                group_len = rec_len;
            end
        end
        start_record();
        if (names_cnt != 0)
            names_cnt = names_cnt - 8'd1;
        if (names_cnt == 0)
            ps = PS_DONE;
    endtask

    function automatic out_word_t make_word(logic [1:0] kind, logic [7:0] ch,
                                            logic [2:0] st, logic last);
        out_word_t w;
        w.item_kind   = kind;
        w.char_value  = ch;
        w.status_code = st;
        w.last_of_run = last;
        return w;
    endfunction

    task automatic parse_byte(input in_word_t w);
        logic [7:0] b;
        logic [2:0] st;
        int i;
        b = w.data_byte;
        case (ps)
            PS_HEADER:
            begin
                if (hdr_seen == ANCOUNT_HI)
                    ancount_hi = b;
                if (hdr_seen == ANCOUNT_LO)
                    have_answers = (ancount_hi | b) != 8'd0;
                hdr_seen = hdr_seen + 4'd1;
                if (hdr_seen >= HDR_BYTES)
                    ps = have_answers ? PS_LABEL : PS_DONE;
            end
            PS_LABEL:
            begin
                if (b == 8'd0)
                begin
                    fixed_cnt = FIXED_BYTES;
                    ps = PS_FIXED;
                end
                else if ((b & PTR_MARK) == PTR_MARK)
                    ps = PS_PTR;
                else
                begin
                    skip_cnt = b;
                    ps = PS_SKIP;
                end
            end
            PS_SKIP:
            begin
                if (skip_cnt != 0)
                    skip_cnt = skip_cnt - 8'd1;
                if (skip_cnt == 0)
                    ps = PS_LABEL;
            end
            PS_PTR:
            begin
                fixed_cnt = FIXED_BYTES;
                ps = PS_FIXED;
            end
            PS_FIXED:
            begin
                if (fixed_cnt != 0)
                    fixed_cnt = fixed_cnt - 4'd1;
                if (fixed_cnt == 0)
                    ps = PS_COUNT;
            end
            PS_COUNT:
            begin
                names_cnt = b;
                start_record();
                ps = (b == 8'd0) ? PS_DONE : PS_RECORDS;
            end
            PS_RECORDS:
            begin
                if (rec_pos < NAME_BYTES)
                begin
                    if (!rec_stop)
                    begin
                        if (b == CHAR_SPACE || b == CHAR_NUL)
                            rec_stop = 1'b1;
                        else if (rec_len < NAME_BYTES)
                        begin
                            rec_name[rec_len] = b;
                            rec_len = rec_len + 4'd1;
                        end
                    end
                end
                else if (rec_pos == NAME_BYTES)
                    rec_type = b;
                else if (rec_pos == NAME_BYTES + 1)
                    rec_grp = (b & GROUP_FLAG) != 8'd0;
                rec_pos = rec_pos + 5'd1;
                if (rec_pos >= RECORD_BYTES)
                    close_record();
            end
            default:
            begin
            end
        endcase

        if (w.end_of_packet)
        begin
            if (ps == PS_HEADER)
                st = ST_SHORT;
            else if (!have_answers)
                st = ST_NO_ANSWER;
            else if (ps != PS_RECORDS && ps != PS_DONE)
                st = ST_TRUNC;
            else
                st = (host_len == 0) ? ST_NO_HOST : ST_OK;
            // names go out only when the parse got as far as the records
            if (st == ST_OK || st == ST_NO_HOST)
            begin
                for (i = 0; i < host_len; i++)
                    expected_words.push_back(make_word(KIND_HOST, host_name[i], ST_OK, 1'b0));
                for (i = 0; i < group_len; i++)
                    expected_words.push_back(make_word(KIND_GROUP, group_name[i], ST_OK,
                                                       1'b0));
            end
            expected_words.push_back(make_word(KIND_STATUS, 8'd0, st, 1'b1));
            status_seen[st]++;
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender: bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_word    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(in_word);
                bytes_taken++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    in_word  <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall pattern plus requested long hold
    // ------------------------------------------------------------------
    int         hold_ack = 0;
    int         hold_left = 0;
    logic [7:0] stall_cyc = '0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_ack  <= 0;
            hold_left <= 0;
            stall_cyc <= '0;
        end
        else
        begin
            stall_cyc <= stall_cyc + 8'd1;
            if (hold_req != hold_ack)
            begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_cyc[7:6])
                    2'd0: out_stall <= 1'b0;
                    2'd1: out_stall <= ($urandom_range(0, 9) < 3);
                    2'd2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (stall_cyc[2:1] == 2'd3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", out_word);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_word.item_kind !== want.item_kind)
                begin
                    $error("item_kind: expected %0d, got %0d", want.item_kind,
                           out_word.item_kind);
                    mismatches++;
                end
                if (out_word.char_value !== want.char_value)
                begin
                    $error("char_value: expected %h, got %h", want.char_value,
                           out_word.char_value);
                    mismatches++;
                end
                if (out_word.status_code !== want.status_code)
                begin
                    $error("status_code: expected %0d, got %0d", want.status_code,
                           out_word.status_code);
                    mismatches++;
                end
                if (out_word.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           out_word.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: no progress while work is outstanding
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (tx_bytes.size() == 0 && !in_valid && expected_words.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: %0d words still expected", expected_words.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CHAR_SPACE)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic add_rand(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_packet();
        in_word_t w;
        int i;
        for (i = 0; i < pkt.size(); i++)
        begin
            w.data_byte     = pkt[i];
            w.end_of_packet = (i == pkt.size() - 1);
            tx_bytes.push_back(w);
        end
        bytes_queued += pkt.size();
        packets_queued++;
        pkt.delete();
    endtask

    task automatic add_header(input logic [15:0] ancount);
        int i;
        for (i = 0; i < HDR_BYTES; i++)
        begin
            if (i == ANCOUNT_HI)
                pkt.push_back(ancount[15:8]);
            else if (i == ANCOUNT_LO)
                pkt.push_back(ancount[7:0]);
            else
                add_rand(1);
        end
    endtask

    function automatic logic [15:0] some_ancount();
        logic [15:0] a;
        case ($urandom_range(0, 2))
            0: a = 16'h0001;
            1: a = 16'h0100;
            default:
            begin
                a = 16'($urandom_range(1, 65535));
            end
        endcase
        return a;
    endfunction

    task automatic add_labels(input int n);
        int len;
        repeat (n)
        begin
            len = $urandom_range(1, 6);
            pkt.push_back(8'(len));
            add_rand(len);
        end
    endtask

    // 0 root, 1 pointer, 2 labels, 3 labels then pointer, 4 long label length
    task automatic add_answer_name(input int form);
        int len;
        case (form)
            0: pkt.push_back(8'h00);
            1:
            begin
                pkt.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                add_rand(1);
            end
            2:
            begin
                add_labels($urandom_range(1, 3));
                pkt.push_back(8'h00);
            end
            3:
            begin
                add_labels($urandom_range(1, 2));
                pkt.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                add_rand(1);
            end
            default:
            begin
                // lengths with only one of the two top bits set still count as labels
                len = ($urandom_range(0, 1) != 0) ? $urandom_range(8'h40, 8'h47)
                                                  : $urandom_range(8'h80, 8'h87);
                pkt.push_back(8'(len));
                add_rand(len);
                pkt.push_back(8'h00);
            end
        endcase
    endtask

    task automatic add_record();
        int nchars;
        int i;
        logic [7:0] kind_byte;
        nchars = ($urandom_range(0, 7) == 0) ? 0 :
                 ($urandom_range(0, 3) == 0) ? NAME_BYTES : $urandom_range(1, NAME_BYTES);
        case ($urandom_range(0, 4))
            0, 1: kind_byte = TYPE_WKSTA;
            2: kind_byte = TYPE_SERVER;
            3: kind_byte = 8'h1D;
            default: kind_byte = 8'($urandom_range(0, 255));
        endcase
        for (i = 0; i < nchars; i++)
            pkt.push_back(name_char());
        if (nchars < NAME_BYTES)
        begin
            pkt.push_back(($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_NUL);
            add_rand(NAME_BYTES - nchars - 1);
        end
        pkt.push_back(kind_byte);
        pkt.push_back({($urandom_range(0, 2) == 0), 7'($urandom_range(0, 127))});
        add_rand(1);
    endtask

    // tail: 0 exact, 1 cut final record, 2 trailing bytes, 3 count byte last,
    //       4 zero count, 5 fewer records than counted
    task automatic build_good_response(input int form, input int tail);
        int n;
        int keep;
        add_header(some_ancount());
        add_answer_name(form);
        add_rand(FIXED_BYTES);
        n = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(1, 2);
        case (tail)
            0:
            begin
                pkt.push_back(8'(n));
                repeat (n) add_record();
            end
            1:
            begin
                pkt.push_back(8'(n));
                repeat (n) add_record();
                keep = $urandom_range(1, RECORD_BYTES - 1);
                repeat (RECORD_BYTES - keep) void'(pkt.pop_back());
            end
            2:
            begin
                pkt.push_back(8'(n));
                repeat (n) add_record();
                add_rand($urandom_range(1, 6));
            end
            3: pkt.push_back(8'($urandom_range(1, 255)));
            4:
            begin
                pkt.push_back(8'h00);
                add_rand($urandom_range(0, 3));
            end
            default:
            begin
                pkt.push_back(8'(n + $urandom_range(1, 3)));
                repeat (n) add_record();
            end
        endcase
        send_packet();
    endtask

    // 0 short, 1 zero answers, 2 cut inside name or fixed part, 3 noise
    task automatic build_bad_response(input int shape);
        case (shape)
            0: add_rand($urandom_range(1, HDR_BYTES - 1));
            1:
            begin
                add_header(16'h0000);
                add_rand($urandom_range(0, 8));
            end
            2:
            begin
                add_header(some_ancount());
                case ($urandom_range(0, 2))
                    0:
                    begin
                        pkt.push_back(8'($urandom_range(3, 63)));
                        add_rand($urandom_range(0, 2));
                    end
                    1: pkt.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                    default:
                    begin
                        pkt.push_back(8'h00);
                        add_rand($urandom_range(0, FIXED_BYTES - 1));
                    end
                endcase
            end
            default: add_rand($urandom_range(12, 30));
        endcase
        send_packet();
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        int extra;
        foreach (status_seen[k])
            status_seen[k] = 0;
        clear_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte packet, all-zero header, pointer as the final byte
        pkt.push_back(8'hFF);
        send_packet();
        repeat (HDR_BYTES) pkt.push_back(8'h00);
        send_packet();
        add_header(16'h0001);
        pkt.push_back(8'hC0);
        send_packet();
        wait_drained();

        // long receiver hold while short packets keep coming
        hold_req = hold_req + 1;
        repeat (6)
        begin
            add_rand($urandom_range(1, 3));
            send_packet();
        end
        wait_drained();

        for (k = 0; k < 6; k++)
            build_good_response(k % 5, k);
        for (k = 0; k < 4; k++)
            build_bad_response(k);

        extra = 0;
        while (bytes_queued < 480 || extra < 6)
        begin
            if ($urandom_range(0, 99) < 65)
                build_good_response(($urandom_range(0, 19) == 0) ? 4 : $urandom_range(0, 3),
                                    $urandom_range(0, 5));
            else
                build_bad_response($urandom_range(0, 3));
            extra++;
            if (extra == 3)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d packets, %0d bytes in, %0d result words checked", packets_queued,
                 bytes_taken, words_checked);
        $display("status mix ok/short/no-answer/truncated/no-host: %0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_NO_ANSWER],
                 status_seen[ST_TRUNC], status_seen[ST_NO_HOST]);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/nbstat_pkg.sv
sv/nbstat_front.sv
sv/nbstat_queue.sv
sv/nbstat_emit.sv
sv/netbios_node_status_parser_core.sv
verif/netbios_node_status_parser_core_tb.sv
